// File: src/plfr_pkg.sv
// ----------------------------------------------------------------------------
// Playfair cipher package
// Shared types, constants and helper functions for the Playfair digraph core.
// ----------------------------------------------------------------------------
package plfr_pkg;

  localparam int SQ_DIM    = 5;
  localparam int LETTER_W  = 5;
  localparam int ROW_W     = SQ_DIM * LETTER_W;
  localparam int COORD_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int DATA_W    = 16;
  localparam int S_USER_W  = 2;
  localparam int M_USER_W  = 1;

  localparam logic [LETTER_W-1:0] FILLER_RESET = LETTER_W'(23);
  localparam logic [COORD_W-1:0]  COORD_LAST   = COORD_W'(SQ_DIM - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_ZERO  = 3'd0,
    REG_ROW_ONE   = 3'd1,
    REG_ROW_TWO   = 3'd2,
    REG_ROW_THREE = 3'd3,
    REG_ROW_FOUR  = 3'd4,
    REG_FILLER    = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    MODE_ENCRYPT = 1'b0,
    MODE_DECRYPT = 1'b1
  } mode_t;

  typedef logic [SQ_DIM-1:0][ROW_W-1:0] square_t;

  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } loc_t;

  function automatic logic [LETTER_W-1:0] cell_at(input square_t sq,
                                                  input logic [COORD_W-1:0] row,
                                                  input logic [COORD_W-1:0] col);
    logic [ROW_W-1:0] row_bits;
    row_bits = sq[row];
    return row_bits[col * LETTER_W +: LETTER_W];
  endfunction

  function automatic logic [COORD_W-1:0] wrap_step(input logic [COORD_W-1:0] idx,
                                                   input logic back);
    logic [COORD_W-1:0] res;
    if (back) begin
      res = (idx == '0) ? COORD_LAST : idx - COORD_W'(1);
    end else begin
      res = (idx == COORD_LAST) ? '0 : idx + COORD_W'(1);
    end
    return res;
  endfunction

endpackage

// File: src/plfr_locate.sv
// ----------------------------------------------------------------------------
// Playfair letter locator
// Compares one letter with all key square entries and returns the row and
// column of the first match in row-major order.
// ----------------------------------------------------------------------------
module plfr_locate import plfr_pkg::*; (
  input  square_t             square,
  input  logic [LETTER_W-1:0] letter,
  output loc_t                loc
);

  always_comb begin
    loc = '0;
    for (int r = SQ_DIM - 1; r >= 0; r--) begin
      for (int c = SQ_DIM - 1; c >= 0; c--) begin
        if (square[r][c*LETTER_W +: LETTER_W] == letter) begin
          loc.found = 1'b1;
          loc.row   = COORD_W'(r);
          loc.col   = COORD_W'(c);
        end
      end
    end
  end

endmodule

// File: src/playfair_digraph_cipher_core.sv
// ----------------------------------------------------------------------------
// Playfair digraph cipher core
// Four-stage pipelined Playfair substitution over a configurable key square.
// ----------------------------------------------------------------------------
// The core takes one letter pair per cycle and returns the substituted pair
// from its output register, at a sustained one word per clock while m_tready
// stays high. The stages are filler substitution, the 25-entry compare and
// locate, the coordinate shift or swap, and the final square lookup into the
// output register. Each stage holds its word independently, so bubbles are
// squeezed out and a stall at the output backs up one stage at a time. The key
// square and filler come from the configuration channel, which is always
// ready and should be written only while no word is in flight.
module playfair_digraph_cipher_core import plfr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [DATA_W-1:0]    s_tdata,   // first_letter[4:0], second_letter[9:5], zero
  input  logic [S_USER_W-1:0]  s_tuser,   // func[0], has_second[1]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [DATA_W-1:0]    m_tdata,   // out_first[4:0], out_second[9:5], zero
  output logic [M_USER_W-1:0]  m_tuser,   // not_found[0]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ROW_W-1:0]     cfg_data
);

  square_t             square;
  logic [LETTER_W-1:0] filler;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      square <= '0;
      filler <= FILLER_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROW_ZERO:  square[0] <= cfg_data;
        REG_ROW_ONE:   square[1] <= cfg_data;
        REG_ROW_TWO:   square[2] <= cfg_data;
        REG_ROW_THREE: square[3] <= cfg_data;
        REG_ROW_FOUR:  square[4] <= cfg_data;
        REG_FILLER:    filler    <= cfg_data[LETTER_W-1:0];
        default: ;
      endcase
    end
  end

  logic                s1_valid, s2_valid, s3_valid;
  logic                s1_ready, s2_ready, s3_ready, m_ready;
  logic                s1_back, s2_back;
  logic [LETTER_W-1:0] s1_a, s1_b, s2_a, s2_b, s3_a, s3_b;
  loc_t                s2_loc1, s2_loc2;
  logic                s3_nf;
  logic [COORD_W-1:0]  s3_r1, s3_c1, s3_r2, s3_c2;

  assign m_ready  = !m_tvalid || m_tready;
  assign s3_ready = !s3_valid || m_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign s_tready = s1_ready;

  logic [LETTER_W-1:0] in_a, in_b, b_eff;
  logic                in_back, in_has;

  assign in_a    = s_tdata[LETTER_W-1:0];
  assign in_b    = s_tdata[2*LETTER_W-1:LETTER_W];
  assign in_back = (s_tuser[0] == MODE_DECRYPT);
  assign in_has  = s_tuser[1];

  always_comb begin
    b_eff = in_has ? in_b : filler;
    if (!in_back && (in_a == b_eff)) begin
      b_eff = filler;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s_tvalid) begin
      s1_a    <= in_a;
      s1_b    <= b_eff;
      s1_back <= in_back;
    end
  end

  loc_t loc1, loc2;

  plfr_locate u_locate_first (
    .square (square),
    .letter (s1_a),
    .loc    (loc1)
  );

  plfr_locate u_locate_second (
    .square (square),
    .letter (s1_b),
    .loc    (loc2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_a    <= s1_a;
      s2_b    <= s1_b;
      s2_back <= s1_back;
      s2_loc1 <= loc1;
      s2_loc2 <= loc2;
    end
  end

  logic [COORD_W-1:0] r1_next, c1_next, r2_next, c2_next;

  always_comb begin
    r1_next = s2_loc1.row;
    c1_next = s2_loc2.col;
    r2_next = s2_loc2.row;
    c2_next = s2_loc1.col;
    if (s2_loc1.row == s2_loc2.row) begin
      c1_next = wrap_step(s2_loc1.col, s2_back);
      c2_next = wrap_step(s2_loc2.col, s2_back);
    end else if (s2_loc1.col == s2_loc2.col) begin
      r1_next = wrap_step(s2_loc1.row, s2_back);
      r2_next = wrap_step(s2_loc2.row, s2_back);
      c1_next = s2_loc1.col;
      c2_next = s2_loc2.col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      s3_a  <= s2_a;
      s3_b  <= s2_b;
      s3_nf <= !(s2_loc1.found && s2_loc2.found);
      s3_r1 <= r1_next;
      s3_c1 <= c1_next;
      s3_r2 <= r2_next;
      s3_c2 <= c2_next;
    end
  end

  logic [LETTER_W-1:0] o1, o2;

  assign o1 = s3_nf ? s3_a : cell_at(square, s3_r1, s3_c1);
  assign o2 = s3_nf ? s3_b : cell_at(square, s3_r2, s3_c2);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (m_ready) begin
      m_tvalid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_ready && s3_valid) begin
      m_tdata <= {{(DATA_W - 2*LETTER_W){1'b0}}, o2, o1};
      m_tuser <= s3_nf;
    end
  end

`ifndef SYNTHESIS
  a_accept_loads_stage1: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> s1_valid)
    else $error("Accepted word did not enter the first stage.");

  a_locate_in_range: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_loc1.found) |-> (s2_loc1.row <= COORD_LAST && s2_loc1.col <= COORD_LAST))
    else $error("Located coordinate outside the key square.");

  a_not_found_passes: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && s3_nf && m_ready) |=>
      (m_tvalid && m_tuser[0] && m_tdata[LETTER_W-1:0] == $past(s3_a)))
    else $error("Missing letter did not pass through unchanged.");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && !m_ready) |=> (s3_valid && $stable(s3_a) && $stable(s3_nf)))
    else $error("Third stage word changed while stalled.");
`endif

endmodule
